/* src/abfp_pkg.sv */
package abfp_pkg;

    localparam int STORE_DEPTH = 12;
    localparam int STORE_IDX_W = $clog2(STORE_DEPTH);

    localparam logic [7:0] OPEN_CHAR  = 8'h24;
    localparam logic [7:0] CLOSE_CHAR = 8'h23;
    localparam logic [7:0] DIGIT_BASE = 8'h30;

    localparam logic REG_FOLLOW_MODE = 1'b0;

    typedef logic [7:0]         byte_t;
    typedef logic signed [15:0] coord_t;
    typedef logic signed [29:0] area_t;
    typedef logic signed [31:0] product_t;

    function automatic coord_t decode3(input byte_t a, input byte_t b, input byte_t c);
        coord_t da;
        coord_t db;
        coord_t dc;
        da = coord_t'({8'b0, a}) - coord_t'({8'b0, DIGIT_BASE});
        db = coord_t'({8'b0, b}) - coord_t'({8'b0, DIGIT_BASE});
        dc = coord_t'({8'b0, c}) - coord_t'({8'b0, DIGIT_BASE});
        return (da <<< 6) + (da <<< 5) + (da <<< 2) + (db <<< 3) + (db <<< 1) + dc;
    endfunction

endpackage

/* src/ascii_box_frame_parser_top.sv */
// Frame parser for '$'-opened, '#'-closed ASCII box reports. One byte is accepted every
// cycle while the result side keeps up; a closing '#' yields one result transaction once
// it has passed through both register stages, the first decoding the digits and the
// second holding the width-by-height product. Bytes that open, fill, abort or fall
// outside a frame produce no result. follow_mode is written through the APB port at
// address 0 and should only be changed while no transaction is in flight.
module ascii_box_frame_parser_top #(
    parameter int MAX_PAYLOAD = 20
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  abfp_pkg::byte_t         s_rx_byte,
    output logic                    m_valid,
    input  logic                    m_ready,
    output abfp_pkg::coord_t        m_center_x,
    output abfp_pkg::coord_t        m_center_y,
    output abfp_pkg::coord_t        m_box_width,
    output abfp_pkg::coord_t        m_box_height,
    output abfp_pkg::area_t         m_box_area,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import abfp_pkg::*;

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAYLOAD);
    localparam logic [CNT_W-1:0] CNT_STORE = CNT_W'(STORE_DEPTH);

    logic              follow_reg;
    logic              in_frame_reg, in_frame_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    byte_t             store_reg [STORE_DEPTH];
    byte_t             store_next [STORE_DEPTH];
    coord_t            held_width_reg, held_width_next;
    coord_t            held_height_reg, held_height_next;

    logic              s1_valid_reg, s1_valid_next;
    coord_t            s1_x_reg, s1_x_next;
    coord_t            s1_y_reg, s1_y_next;
    coord_t            s1_w_reg, s1_w_next;
    coord_t            s1_h_reg, s1_h_next;

    logic              m_valid_reg, m_valid_next;
    coord_t            m_x_reg, m_x_next;
    coord_t            m_y_reg, m_y_next;
    coord_t            m_w_reg, m_w_next;
    coord_t            m_h_reg, m_h_next;
    area_t             m_area_reg, m_area_next;

    logic              out_take;
    logic              s1_take;
    logic              in_take;
    logic              result_fire;
    coord_t            dec_w;
    coord_t            dec_h;
    product_t          product;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FOLLOW_MODE) ? {31'b0, follow_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            follow_reg <= 1'b0;
        end else if (psel && penable && pwrite && (paddr[2] == REG_FOLLOW_MODE)) begin
            follow_reg <= pwdata[0];
        end
    end

    assign out_take = !m_valid_reg || m_ready;
    assign s1_take  = !s1_valid_reg || out_take;
    assign s_ready  = s1_take;
    assign in_take  = s_valid && s_ready;

    assign dec_w = decode3(store_reg[6], store_reg[7], store_reg[8]);
    assign dec_h = decode3(store_reg[9], store_reg[10], store_reg[11]);
    assign product = product_t'(s1_w_reg) * product_t'(s1_h_reg);

    always_comb begin
        in_frame_next    = in_frame_reg;
        count_next       = count_reg;
        store_next       = store_reg;
        held_width_next  = held_width_reg;
        held_height_next = held_height_reg;
        result_fire      = 1'b0;
        if (in_take) begin
            if (!in_frame_reg) begin
                if (s_rx_byte == OPEN_CHAR) begin
                    in_frame_next = 1'b1;
                    count_next    = '0;
                    for (int i = 0; i < STORE_DEPTH; i++) begin
                        store_next[i] = '0;
                    end
                end
            end else if (s_rx_byte == CLOSE_CHAR) begin
                result_fire   = 1'b1;
                in_frame_next = 1'b0;
                count_next    = '0;
                for (int i = 0; i < STORE_DEPTH; i++) begin
                    store_next[i] = '0;
                end
                if (follow_reg) begin
                    held_width_next  = dec_w;
                    held_height_next = dec_h;
                end
            end else if (s_rx_byte != OPEN_CHAR) begin
                if (count_reg >= CNT_MAX) begin
                    in_frame_next = 1'b0;
                    count_next    = '0;
                    for (int i = 0; i < STORE_DEPTH; i++) begin
                        store_next[i] = '0;
                    end
                end else begin
                    if (count_reg < CNT_STORE) begin
                        store_next[count_reg[STORE_IDX_W-1:0]] = s_rx_byte;
                    end
                    count_next = count_reg + CNT_W'(1);
                end
            end
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        s1_x_next     = s1_x_reg;
        s1_y_next     = s1_y_reg;
        s1_w_next     = s1_w_reg;
        s1_h_next     = s1_h_reg;
        if (s1_take) begin
            s1_valid_next = result_fire;
            s1_x_next     = decode3(store_reg[0], store_reg[1], store_reg[2]);
            s1_y_next     = decode3(store_reg[3], store_reg[4], store_reg[5]);
            s1_w_next     = follow_reg ? dec_w : held_width_reg;
            s1_h_next     = follow_reg ? dec_h : held_height_reg;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_x_next     = m_x_reg;
        m_y_next     = m_y_reg;
        m_w_next     = m_w_reg;
        m_h_next     = m_h_reg;
        m_area_next  = m_area_reg;
        if (out_take) begin
            m_valid_next = s1_valid_reg;
            m_x_next     = s1_x_reg;
            m_y_next     = s1_y_reg;
            m_w_next     = s1_w_reg;
            m_h_next     = s1_h_reg;
            m_area_next  = product[29:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg    <= 1'b0;
            count_reg       <= '0;
            held_width_reg  <= '0;
            held_height_reg <= '0;
            s1_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            for (int i = 0; i < STORE_DEPTH; i++) begin
                store_reg[i] <= '0;
            end
        end else begin
            in_frame_reg    <= in_frame_next;
            count_reg       <= count_next;
            held_width_reg  <= held_width_next;
            held_height_reg <= held_height_next;
            s1_valid_reg    <= s1_valid_next;
            m_valid_reg     <= m_valid_next;
            store_reg       <= store_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_x_reg   <= s1_x_next;
        s1_y_reg   <= s1_y_next;
        s1_w_reg   <= s1_w_next;
        s1_h_reg   <= s1_h_next;
        m_x_reg    <= m_x_next;
        m_y_reg    <= m_y_next;
        m_w_reg    <= m_w_next;
        m_h_reg    <= m_h_next;
        m_area_reg <= m_area_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_center_x   = m_x_reg;
    assign m_center_y   = m_y_reg;
    assign m_box_width  = m_w_reg;
    assign m_box_height = m_h_reg;
    assign m_box_area   = m_area_reg;

endmodule
